@@ design/rpa_pkg.sv @@
package rpa_pkg;

  localparam int ADDR_W      = 22;
  localparam int CMD_W       = 3;
  localparam int STATUS_W    = 3;
  localparam int OUT_COUNT_W = 8;

  localparam logic [CMD_W-1:0] CMD_ALLOC    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FREE     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INC      = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DEC      = 3'd3;
  localparam logic [CMD_W-1:0] CMD_GET      = 3'd4;
  localparam logic [CMD_W-1:0] CMD_ADD_FREE = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BADADDR = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UNDER   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OVER    = 3'd4;

endpackage

@@ design/refcounted_page_allocator.sv @@
// Page allocator: a LIFO stack of free page numbers plus one reference count per
// page, both held in single-port-write synchronous RAMs. Each request is a memory
// read, then modify and write back, and no new request is accepted until the last
// one is done; the result sits in an output register, and a stall on the result
// side holds the block in its write-back cycle. After reset the count RAM is
// cleared one entry per cycle, during which in_ready stays low (low_addr writes
// are taken at any time).
module refcounted_page_allocator #(
  parameter int NUM_PAGES  = 1024,
  parameter int PAGE_SHIFT = 12,
  parameter int COUNT_BITS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,

  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rpa_pkg::ADDR_W-1:0]           cfg_low_addr,

  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [rpa_pkg::CMD_W-1:0]            in_command,
  input  logic [rpa_pkg::ADDR_W-1:0]           in_addr,

  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [rpa_pkg::STATUS_W-1:0]         out_status,
  output logic [rpa_pkg::ADDR_W-1:0]           out_page_addr,
  output logic [rpa_pkg::OUT_COUNT_W-1:0]      out_count
);

  localparam int PW = $clog2(NUM_PAGES);
  localparam int TW = $clog2(NUM_PAGES + 1);
  localparam logic [PW-1:0]         LAST_PAGE = PW'(NUM_PAGES - 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX   = '1;
  localparam logic [COUNT_BITS-1:0] CNT_ONE   = COUNT_BITS'(1);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0]                     state_r, state_nxt;
  logic [PW-1:0]                  clr_idx_r;
  logic [TW-1:0]                  top_r;
  logic [rpa_pkg::ADDR_W-1:0]     low_addr_r;
  logic [rpa_pkg::CMD_W-1:0]      cmd_r;
  logic [rpa_pkg::ADDR_W-1:0]     addr_r;

  logic                           out_valid_r;
  logic [rpa_pkg::STATUS_W-1:0]   out_status_r;
  logic [rpa_pkg::ADDR_W-1:0]     out_page_addr_r;
  logic [rpa_pkg::OUT_COUNT_W-1:0] out_count_r;

  logic                           accept, go;
  logic [31:0]                    in_idx_wide, idx_wide;
  logic [PW-1:0]                  in_idx, idx;
  logic                           in_range, addr_ok, can_push;

  logic [COUNT_BITS-1:0]          cnt_rd;
  logic [PW-1:0]                  stk_rd;

  // execute-cycle results
  logic [rpa_pkg::STATUS_W-1:0]   ex_status;
  logic [rpa_pkg::ADDR_W-1:0]     ex_page_addr;
  logic [COUNT_BITS-1:0]          ex_count;
  logic                           ex_cw_en;
  logic [PW-1:0]                  ex_cw_addr;
  logic [COUNT_BITS-1:0]          ex_cw_data;
  logic                           ex_push;
  logic                           ex_pop;
  logic [31:0]                    pop_addr_wide;
  logic [31:0]                    ex_count_wide;

  logic                           cnt_we;
  logic [PW-1:0]                  cnt_waddr;
  logic [COUNT_BITS-1:0]          cnt_wdata;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign go        = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  assign in_idx_wide = 32'(in_addr) >> PAGE_SHIFT;
  assign in_idx      = in_idx_wide[PW-1:0];
  assign idx_wide    = 32'(addr_r) >> PAGE_SHIFT;
  assign idx         = idx_wide[PW-1:0];
  assign in_range    = idx_wide < 32'(NUM_PAGES);
  assign addr_ok     = (addr_r[PAGE_SHIFT-1:0] == '0) && (addr_r >= low_addr_r) && in_range;
  assign can_push    = 32'(top_r) < 32'(NUM_PAGES);
  assign pop_addr_wide = 32'(stk_rd) << PAGE_SHIFT;

  rpa_ram #(
    .DEPTH (NUM_PAGES),
    .WIDTH (COUNT_BITS)
  ) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (accept),
    .raddr (in_idx),
    .rdata (cnt_rd)
  );

  logic [TW-1:0] top_dec;
  assign top_dec = top_r - TW'(1);

  rpa_ram #(
    .DEPTH (NUM_PAGES),
    .WIDTH (PW)
  ) u_stack_ram (
    .clk   (clk),
    .we    (go && ex_push),
    .waddr (top_r[PW-1:0]),
    .wdata (idx),
    .re    (accept && (top_r != '0)),
    .raddr (top_dec[PW-1:0]),
    .rdata (stk_rd)
  );

  always_comb begin
    ex_status    = rpa_pkg::ST_OK;
    ex_page_addr = '0;
    ex_count     = '0;
    ex_cw_en     = 1'b0;
    ex_cw_addr   = idx;
    ex_cw_data   = '0;
    ex_push      = 1'b0;
    ex_pop       = 1'b0;
    unique case (cmd_r)
      rpa_pkg::CMD_ALLOC: begin
        if (top_r == '0) begin
          ex_status = rpa_pkg::ST_EMPTY;
        end else begin
          ex_pop       = 1'b1;
          ex_cw_en     = 1'b1;
          ex_cw_addr   = stk_rd;
          ex_cw_data   = CNT_ONE;
          ex_count     = CNT_ONE;
          ex_page_addr = pop_addr_wide[rpa_pkg::ADDR_W-1:0];
        end
      end
      rpa_pkg::CMD_FREE: begin
        if (!addr_ok) begin
          ex_status = rpa_pkg::ST_BADADDR;
        end else if (cnt_rd == '0) begin
          ex_status = rpa_pkg::ST_UNDER;
        end else begin
          ex_cw_en   = 1'b1;
          ex_cw_data = cnt_rd - CNT_ONE;
          ex_count   = cnt_rd - CNT_ONE;
          ex_push    = (cnt_rd == CNT_ONE) && can_push;
        end
      end
      rpa_pkg::CMD_ADD_FREE: begin
        if (!addr_ok) begin
          ex_status = rpa_pkg::ST_BADADDR;
        end else begin
          ex_cw_en = 1'b1;
          ex_push  = can_push;
        end
      end
      rpa_pkg::CMD_INC: begin
        if (!in_range) begin
          ex_status = rpa_pkg::ST_BADADDR;
        end else if (cnt_rd == CNT_MAX) begin
          ex_status = rpa_pkg::ST_OVER;
          ex_count  = CNT_MAX;
        end else begin
          ex_cw_en   = 1'b1;
          ex_cw_data = cnt_rd + CNT_ONE;
          ex_count   = cnt_rd + CNT_ONE;
        end
      end
      rpa_pkg::CMD_DEC: begin
        if (!in_range) begin
          ex_status = rpa_pkg::ST_BADADDR;
        end else if (cnt_rd == '0) begin
          ex_status = rpa_pkg::ST_UNDER;
        end else begin
          ex_cw_en   = 1'b1;
          ex_cw_data = cnt_rd - CNT_ONE;
          ex_count   = cnt_rd - CNT_ONE;
        end
      end
      rpa_pkg::CMD_GET: begin
        if (!in_range) begin
          ex_status = rpa_pkg::ST_BADADDR;
        end else begin
          ex_count = cnt_rd;
        end
      end
      default: begin
      end
    endcase
  end

  assign ex_count_wide = 32'(ex_count);

  // the clearing sweep owns the count RAM write port until it finishes
  always_comb begin
    if (state_r == S_CLEAR) begin
      cnt_we    = 1'b1;
      cnt_waddr = clr_idx_r;
      cnt_wdata = '0;
    end else begin
      cnt_we    = go && ex_cw_en;
      cnt_waddr = ex_cw_addr;
      cnt_wdata = ex_cw_data;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_idx_r == LAST_PAGE) state_nxt = S_IDLE;
      S_IDLE:  if (accept) state_nxt = S_EXEC;
      S_EXEC:  if (go) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      top_r       <= '0;
      low_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_idx_r <= clr_idx_r + PW'(1);
      end
      if (cfg_valid) begin
        low_addr_r <= cfg_low_addr;
      end
      if (go) begin
        out_valid_r <= 1'b1;
        if (ex_pop) begin
          top_r <= top_dec;
        end else if (ex_push) begin
          top_r <= top_r + TW'(1);
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= in_command;
      addr_r <= in_addr;
    end
    if (go) begin
      out_status_r    <= ex_status;
      out_page_addr_r <= ex_page_addr;
      out_count_r     <= ex_count_wide[rpa_pkg::OUT_COUNT_W-1:0];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_page_addr = out_page_addr_r;
  assign out_count     = out_count_r;

endmodule

@@ design/rpa_ram.sv @@
module rpa_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
